>>> rtl/tstl_pkg.sv
// Shared constants and types for the thread slot table.
package tstl_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int TID_W     = 31;
	localparam int STAMP_W   = 64;
	localparam int OUT_IDX_W = 4;
	localparam int OUT_CNT_W = 5;
	localparam int LATENCY   = NUM_SLOTS + 3;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FIN   = 2'd2;
	localparam logic [1:0] ST_WRITE = 2'd3;

	typedef struct packed {
		logic             clr;
		logic             ev;
		logic [IDX_W-1:0] idx;
		logic             valid;
	} scan_ctl_t;

	typedef struct packed {
		logic             claim;
		logic [IDX_W-1:0] sel;
	} scan_res_t;

endpackage

>>> rtl/thread_slot_table_lru.sv
// Top level of the thread slot table with least-recently-stamped replacement.
// A new update is accepted only while busy is low, so updates never overlap.
// The scan reads one slot a cycle; the shared compare unit and the single memory read
// port set that rate.
// Reset frees every slot at once through the valid flops; no clearing pass is needed.
// The result beat is shown for one cycle and the receiver cannot stall it.
module thread_slot_table_lru (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [tstl_pkg::TID_W-1:0]           thread_id,
	input  logic [tstl_pkg::STAMP_W-1:0]         cycle_stamp,
	output logic                                 done,
	output logic [tstl_pkg::OUT_IDX_W-1:0]       slot_index,
	output logic [tstl_pkg::OUT_CNT_W-1:0]       active_count
);

	logic [1:0]                       state_q;
	logic [tstl_pkg::IDX_W-1:0]       addr_q;
	logic [tstl_pkg::IDX_W-1:0]       idx_s1;
	logic                             ev_s1;
	logic [tstl_pkg::NUM_SLOTS-1:0]   valid_q;
	logic [tstl_pkg::CNT_W-1:0]       count_q;
	logic [tstl_pkg::CNT_W-1:0]       count_next;
	logic [tstl_pkg::TID_W-1:0]       id_q;
	logic [tstl_pkg::STAMP_W-1:0]     stamp_q;
	logic                             done_q;
	logic [tstl_pkg::OUT_IDX_W-1:0]   slot_q;
	logic [tstl_pkg::OUT_CNT_W-1:0]   act_q;
	logic [tstl_pkg::TID_W-1:0]       rowner;
	logic [tstl_pkg::STAMP_W-1:0]     rstamp;
	logic                             accept;
	logic                             last;
	logic                             wr;
	logic [tstl_pkg::IDX_W+tstl_pkg::OUT_IDX_W-1:0] sel_ext;
	logic [tstl_pkg::CNT_W+tstl_pkg::OUT_CNT_W-1:0] cnt_ext;
	tstl_pkg::scan_ctl_t              ctl;
	tstl_pkg::scan_res_t              res;

	assign busy       = (state_q != tstl_pkg::ST_IDLE);
	assign accept     = start && !busy;
	assign last       = (addr_q == tstl_pkg::IDX_W'(tstl_pkg::NUM_SLOTS - 1));
	assign wr         = (state_q == tstl_pkg::ST_WRITE);
	assign count_next = count_q + tstl_pkg::CNT_W'(res.claim);
	assign sel_ext    = {{tstl_pkg::OUT_IDX_W{1'b0}}, res.sel};
	assign cnt_ext    = {{tstl_pkg::OUT_CNT_W{1'b0}}, count_next};

	assign ctl.clr   = accept;
	assign ctl.ev    = ev_s1;
	assign ctl.idx   = idx_s1;
	assign ctl.valid = valid_q[idx_s1];

	tstl_store u_store (
		.clk    (clk),
		.we     (wr),
		.waddr  (res.sel),
		.wowner (id_q),
		.wstamp (stamp_q),
		.raddr  (addr_q),
		.rowner (rowner),
		.rstamp (rstamp)
	);

	tstl_cmp u_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.id     (id_q),
		.owner  (rowner),
		.stamp  (rstamp),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tstl_pkg::ST_IDLE;
			addr_q  <= '0;
			ev_s1   <= 1'b0;
			valid_q <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			ev_s1  <= (state_q == tstl_pkg::ST_SCAN);
			done_q <= wr;
			case (state_q)
				tstl_pkg::ST_IDLE: begin
					addr_q <= '0;
					if (accept) begin
						state_q <= tstl_pkg::ST_SCAN;
					end
				end
				tstl_pkg::ST_SCAN: begin
					if (last) begin
						state_q <= tstl_pkg::ST_FIN;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				tstl_pkg::ST_FIN: begin
					state_q <= tstl_pkg::ST_WRITE;
				end
				tstl_pkg::ST_WRITE: begin
					valid_q[res.sel] <= 1'b1;
					count_q          <= count_next;
					state_q          <= tstl_pkg::ST_IDLE;
				end
				default: begin
					state_q <= tstl_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (accept) begin
			id_q    <= thread_id;
			stamp_q <= cycle_stamp;
		end
		if (wr) begin
			slot_q <= sel_ext[tstl_pkg::OUT_IDX_W-1:0];
			act_q  <= cnt_ext[tstl_pkg::OUT_CNT_W-1:0];
		end
	end

	assign done         = done_q;
	assign slot_index   = slot_q;
	assign active_count = act_q;

endmodule

>>> rtl/tstl_store.sv
// Owner and stamp memory with one write port and one registered read port.
module tstl_store (
	input  logic                         clk,
	input  logic                         we,
	input  logic [tstl_pkg::IDX_W-1:0]   waddr,
	input  logic [tstl_pkg::TID_W-1:0]   wowner,
	input  logic [tstl_pkg::STAMP_W-1:0] wstamp,
	input  logic [tstl_pkg::IDX_W-1:0]   raddr,
	output logic [tstl_pkg::TID_W-1:0]   rowner,
	output logic [tstl_pkg::STAMP_W-1:0] rstamp
);

	logic [tstl_pkg::TID_W-1:0]   owner_mem [tstl_pkg::NUM_SLOTS];
	logic [tstl_pkg::STAMP_W-1:0] stamp_mem [tstl_pkg::NUM_SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			owner_mem[waddr] <= wowner;
			stamp_mem[waddr] <= wstamp;
		end
		rowner <= owner_mem[raddr];
		rstamp <= stamp_mem[raddr];
	end

endmodule

>>> rtl/tstl_cmp.sv
// Shared compare unit that folds one slot per beat into hit, free and oldest picks.
module tstl_cmp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tstl_pkg::scan_ctl_t          ctl,
	input  logic [tstl_pkg::TID_W-1:0]   id,
	input  logic [tstl_pkg::TID_W-1:0]   owner,
	input  logic [tstl_pkg::STAMP_W-1:0] stamp,
	output tstl_pkg::scan_res_t          res
);

	logic                           hit_q;
	logic                           free_q;
	logic [tstl_pkg::IDX_W-1:0]     hit_idx_q;
	logic [tstl_pkg::IDX_W-1:0]     free_idx_q;
	logic [tstl_pkg::IDX_W-1:0]     min_idx_q;
	logic [tstl_pkg::STAMP_W-1:0]   min_q;
	logic                           is_hit;
	logic                           older;

	assign is_hit = ctl.valid && (owner == id);
	assign older  = (ctl.idx == '0) || (stamp < min_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (ctl.clr) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (ctl.ev) begin
			if (is_hit && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!ctl.valid && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ev) begin
			if (is_hit && !hit_q) begin
				hit_idx_q <= ctl.idx;
			end
			if (!ctl.valid && !free_q) begin
				free_idx_q <= ctl.idx;
			end
			if (older) begin
				min_q     <= stamp;
				min_idx_q <= ctl.idx;
			end
		end
	end

	always_comb begin
		res.claim = !hit_q && free_q;
		if (hit_q) begin
			res.sel = hit_idx_q;
		end else if (free_q) begin
			res.sel = free_idx_q;
		end else begin
			res.sel = min_idx_q;
		end
	end

endmodule

>>> rtl/tstl_chk.sv
// Port-level checker for the thread slot table, bound to the top level.
module tstl_chk (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 busy,
	input  logic                                 done,
	input  logic [tstl_pkg::OUT_CNT_W-1:0]       active_count
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("A result beat appeared while the block was busy.");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("The block did not go busy after accepting a beat.");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(tstl_pkg::LATENCY) done)
		else $error("The result beat did not arrive at the expected latency.");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (active_count != '0))
		else $error("A result beat reported no occupied slots.");

endmodule

bind thread_slot_table_lru tstl_chk u_tstl_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.active_count (active_count)
);

>>> tb/thread_slot_table_lru_tb.sv
// Self-checking testbench for the thread slot table with least-recently-stamped replacement.
module thread_slot_table_lru_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tstl_pkg::*;

	localparam int RANDOM_UPDATES = 1800;
	localparam int STALL_LIMIT    = 1000;
	localparam int ID_POOL        = 24;
	localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
	localparam logic [TID_W-1:0]   TID_MAX   = '1;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] idx;
		logic [OUT_CNT_W-1:0] cnt;
	} slot_result_t;

	typedef struct {
		logic [TID_W-1:0]   id;
		logic [STAMP_W-1:0] stamp;
		bit                 typed;
		slot_result_t       res;
	} update_row_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 start       = 1'b0;
	logic [TID_W-1:0]     thread_id   = '0;
	logic [STAMP_W-1:0]   cycle_stamp = '0;
	logic                 busy;
	logic                 done;
	logic [OUT_IDX_W-1:0] slot_index;
	logic [OUT_CNT_W-1:0] active_count;

	bit                 model_occupied[NUM_SLOTS];
	logic [TID_W-1:0]   model_owner[NUM_SLOTS];
	logic [STAMP_W-1:0] model_recency[NUM_SLOTS];

	slot_result_t       pending_results[$];
	update_row_t        directed_rows[$];
	logic [TID_W-1:0]   id_pool[ID_POOL];
	logic [STAMP_W-1:0] stamp_clock;
	int                 fail_count   = 0;
	int                 quiet_cycles = 0;
	int                 gap_mode     = 1;

	thread_slot_table_lru dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.thread_id    (thread_id),
		.cycle_stamp  (cycle_stamp),
		.done         (done),
		.slot_index   (slot_index),
		.active_count (active_count)
	);

	always #4ns clk = ~clk;

	function automatic slot_result_t claim_slot(input logic [TID_W-1:0] id,
			input logic [STAMP_W-1:0] stamp);
		int           chosen;
		int           occupied;
		slot_result_t res;
		chosen   = -1;
		occupied = 0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (chosen < 0 && model_occupied[i] && model_owner[i] == id)
				chosen = i;
		end
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (chosen < 0 && !model_occupied[i])
				chosen = i;
		end
		if (chosen < 0) begin
			chosen = 0;
			for (int i = 1; i < NUM_SLOTS; i++) begin
				if (model_recency[i] < model_recency[chosen])
					chosen = i;
			end
		end
		model_occupied[chosen] = 1'b1;
		model_owner[chosen]    = id;
		model_recency[chosen]  = stamp;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (model_occupied[i])
				occupied++;
		end
		res.idx = OUT_IDX_W'(chosen);
		res.cnt = OUT_CNT_W'(occupied);
		return res;
	endfunction

	function automatic void add_row(input logic [TID_W-1:0] id, input logic [STAMP_W-1:0] stamp,
			input bit typed, input int idx, input int cnt);
		update_row_t row;
		row.id      = id;
		row.stamp   = stamp;
		row.typed   = typed;
		row.res.idx = OUT_IDX_W'(idx);
		row.res.cnt = OUT_CNT_W'(cnt);
		directed_rows.push_back(row);
	endfunction

	function automatic int next_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (gap_mode == 0 || pick < 55)
			return 0;
		else if (pick < 92)
			return $urandom_range(1, 22);
		else
			return $urandom_range(30, 120);
	endfunction

	task automatic send_update(input logic [TID_W-1:0] id, input logic [STAMP_W-1:0] stamp,
			input int gap);
		if (gap > 0) begin
			@(negedge clk);
			start       <= 1'b0;
			thread_id   <= TID_W'($urandom);
			cycle_stamp <= {$urandom, $urandom};
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start       <= 1'b1;
		thread_id   <= id;
		cycle_stamp <= stamp;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	always @(posedge clk) begin : check_result
		slot_result_t due;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with none expected, slot_index %0d active_count %0d",
					$time, slot_index, active_count);
				fail_count++;
			end else begin
				due = pending_results.pop_front();
				if (slot_index !== due.idx) begin
					$display("%0t: slot_index expected %0d, got %0d", $time, due.idx, slot_index);
					fail_count++;
				end
				if (active_count !== due.cnt) begin
					$display("%0t: active_count expected %0d, got %0d",
						$time, due.cnt, active_count);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
			$display("** thread_slot_table_lru: FAILED **");
			$finish;
		end
	end

	initial begin
		update_row_t        row;
		slot_result_t       due;
		logic [TID_W-1:0]   id;
		logic [STAMP_W-1:0] stamp;
		int                 pick;

		for (int i = 0; i < NUM_SLOTS; i++) begin
			model_occupied[i] = 1'b0;
			model_owner[i]    = '0;
			model_recency[i]  = '0;
		end
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Claims from empty, hits with stamps going backwards, a full table of maximum
		// stamps so that slot 0 is evicted, then evictions by strictly smallest stamp.
		add_row(TID_MAX, STAMP_MAX, 1, 0, 1);
		add_row('0, '0, 1, 1, 2);
		add_row(TID_MAX, 64'd5, 1, 0, 2);
		add_row('0, STAMP_MAX, 1, 1, 2);
		add_row(TID_MAX, STAMP_MAX, 1, 0, 2);
		for (int s = 2; s < NUM_SLOTS; s++)
			add_row(TID_W'(s), STAMP_MAX, 1, s, s + 1);
		add_row(31'd100, STAMP_MAX, 1, 0, NUM_SLOTS);
		add_row(31'd101, 64'h5555_5555_5555_5555, 1, 0, NUM_SLOTS);
		add_row(31'd102, 64'hAAAA_AAAA_AAAA_AAAA, 1, 0, NUM_SLOTS);
		add_row('0, 64'd1, 1, 1, NUM_SLOTS);
		add_row(31'd103, '0, 1, 1, NUM_SLOTS);
		add_row(31'd104, 64'd1, 0, 0, 0);

		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			send_update(row.id, row.stamp, next_gap());
			due = claim_slot(row.id, row.stamp);
			if (row.typed)
				due = row.res;
			pending_results.push_back(due);
		end

		// Mostly a small working set of threads with a rising clock, so that hits and
		// evictions both stay frequent; the rest are stray ids and wild stamps.
		foreach (id_pool[p])
			id_pool[p] = TID_W'($urandom);
		id_pool[0]  = '0;
		id_pool[1]  = TID_MAX;
		id_pool[2]  = 31'd2;
		id_pool[3]  = 31'd100;
		stamp_clock = 64'd1000;
		for (int n = 0; n < RANDOM_UPDATES; n++) begin
			if (n % 150 == 0)
				gap_mode = $urandom_range(0, 3);
			pick = $urandom_range(0, 99);
			if (pick < 4)
				id_pool[$urandom_range(0, ID_POOL - 1)] = TID_W'($urandom);
			if (pick < 65)
				id = id_pool[$urandom_range(0, ID_POOL - 1)];
			else if (pick < 85)
				id = id_pool[$urandom_range(0, 5)];
			else
				id = TID_W'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				stamp_clock = stamp_clock + $urandom_range(1, 40);
				stamp       = stamp_clock;
			end else if (pick < 67)
				stamp = stamp_clock;
			else if (pick < 77)
				stamp = stamp_clock - $urandom_range(1, 200);
			else if (pick < 87)
				stamp = {$urandom, $urandom};
			else if (pick < 93)
				stamp = STAMP_W'($urandom_range(0, 3));
			else if (pick < 97)
				stamp = STAMP_MAX - $urandom_range(0, 1);
			else begin
				stamp_clock = {$urandom, $urandom} >> $urandom_range(0, 63);
				stamp       = stamp_clock;
			end
			send_update(id, stamp, next_gap());
			pending_results.push_back(claim_slot(id, stamp));
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (fail_count == 0)
			$display("** thread_slot_table_lru: PASSED **");
		else
			$display("** thread_slot_table_lru: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
rtl/tstl_pkg.sv
rtl/tstl_store.sv
rtl/tstl_cmp.sv
rtl/thread_slot_table_lru.sv
rtl/tstl_chk.sv
tb/thread_slot_table_lru_tb.sv
